// ----- rtl/mlfd_pkg.sv -----
// Shared types and constants for the magic-word, length-prefixed Fletcher-16 frame receiver.
package mlfd_pkg;

	// Width of the length field that the receiver accepts.
	localparam int LENGTH_BITS = 16;

	localparam int POS_BITS = 17;
	localparam int HEADER_BYTES = 4;

	// Largest length that fits in LENGTH_BITS bits, held one bit wider than the length word.
	localparam logic [16:0] LEN_CAP = 17'((64'd1 << LENGTH_BITS) - 64'd1);

	// Fixed byte positions within a frame header.
	localparam logic [POS_BITS-1:0] POS_HUNT     = 17'd0;
	localparam logic [POS_BITS-1:0] POS_MAGIC_LO = 17'd1;
	localparam logic [POS_BITS-1:0] POS_LEN_HI   = 17'd2;
	localparam logic [POS_BITS-1:0] POS_LEN_LO   = 17'd3;
	localparam logic [POS_BITS-1:0] POS_PAYLOAD  = 17'(HEADER_BYTES);

	// Fletcher-16 sums wrap at this modulus.
	localparam logic [8:0] FL_MOD = 9'h0FF;

	typedef enum logic [1:0] {
		KIND_DATA    = 2'd0,
		KIND_GOOD    = 2'd1,
		KIND_BAD_SUM = 2'd2,
		KIND_BAD_LEN = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		CFG_ENABLE  = 2'd0,
		CFG_MAGIC   = 2'd1,
		CFG_MAX_LEN = 2'd2
	} cfg_idx_t;

	// Control from the frame sequencer to the checksum unit.
	typedef struct packed {
		logic clear;
		logic update;
	} fl_ctl_t;

endpackage

// ----- rtl/mlfd_fletcher.sv -----
// Running Fletcher-16 accumulator with clear and per-byte update.
module mlfd_fletcher (
	input  logic              clk,
	input  logic              arst_n,
	input  mlfd_pkg::fl_ctl_t ctl,
	input  logic [7:0]        data,
	output logic [15:0]       check_word
);

	logic [7:0] sum_low_q;
	logic [7:0] sum_high_q;
	logic [7:0] low_next;
	logic [7:0] high_next;

	// Adds two values modulo 255; the first operand is always below 255, so one
	// conditional subtraction is enough.
	function automatic logic [7:0] add_mod(input logic [7:0] a, input logic [7:0] b);
		logic [8:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= mlfd_pkg::FL_MOD) begin
			s = s - mlfd_pkg::FL_MOD;
		end
		return s[7:0];
	endfunction

	assign low_next   = add_mod(sum_low_q, data);
	assign high_next  = add_mod(sum_high_q, low_next);
	assign check_word = {sum_high_q, sum_low_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_low_q  <= '0;
			sum_high_q <= '0;
		end else if (ctl.clear) begin
			sum_low_q  <= '0;
			sum_high_q <= '0;
		end else if (ctl.update) begin
			sum_low_q  <= low_next;
			sum_high_q <= high_next;
		end
	end

endmodule

// ----- rtl/magic_length_fletcher_deframer.sv -----
// Top level of the magic-word, length-prefixed frame receiver with Fletcher-16 check.
// Each result is held in the output register, loaded as the byte that causes it is taken.
// Throughput: one byte per cycle; a byte is taken whenever the output register is empty
// or its result is being taken in the same cycle.
// Reset (arst_n low, asynchronous): receiver disabled, magic word zero, length limit 256,
// hunting for the magic word, checksum sums cleared, output register empty.
module magic_length_fletcher_deframer (
	input  logic        clk,
	input  logic        arst_n,
	// byte input
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	// result output
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [7:0]  payload_byte,
	output logic [15:0] frame_length,
	output logic [15:0] frame_checksum,
	// configuration writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int PB = mlfd_pkg::POS_BITS;

	// Configuration registers.
	logic        enable_q;
	logic [15:0] magic_q;
	logic [15:0] max_len_q;

	// Frame state: position within the frame, the length word and the first checksum byte.
	logic [PB-1:0] pos_q;
	logic [15:0]   len_q;
	logic [7:0]    ck_hi_q;

	// Output register.
	logic        out_valid_q;
	logic [1:0]  kind_q;
	logic [7:0]  payload_q;
	logic [15:0] length_q;
	logic [15:0] checksum_q;

	// Next-state and result, worked out from the byte on the input.
	logic          in_fire;
	logic [PB-1:0] pos_next;
	logic [15:0]   len_next;
	logic          ck_hi_load;
	logic          res_valid;
	mlfd_pkg::kind_t res_kind;
	logic [7:0]    res_payload;
	logic [15:0]   res_length;
	logic [15:0]   res_checksum;
	logic [PB-1:0] idx;
	logic [15:0]   len_full;
	logic          len_bad;
	logic [15:0]   received;
	logic [15:0]   computed;
	mlfd_pkg::fl_ctl_t fl_ctl;

	// The output register is freed by a completed output transaction, so a new byte can
	// be taken in the same cycle that the previous result leaves.
	assign in_ready  = !out_valid_q || out_ready;
	assign in_fire   = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	// Configuration writes; an index beyond the register list is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q  <= 1'b0;
			magic_q   <= '0;
			max_len_q <= 16'd256;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				mlfd_pkg::CFG_ENABLE:  enable_q  <= cfg_data[0];
				mlfd_pkg::CFG_MAGIC:   magic_q   <= cfg_data;
				mlfd_pkg::CFG_MAX_LEN: max_len_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Index of the current byte within the payload and checksum part of the frame.
	assign idx      = pos_q - mlfd_pkg::POS_PAYLOAD;
	// Length word as it stands once the low length byte is in.
	assign len_full = {len_q[15:8], rx_byte};
	// A length is refused when it exceeds the programmed limit or the supported width.
	assign len_bad  = ({1'b0, len_full} > {1'b0, max_len_q}) ||
		({1'b0, len_full} > mlfd_pkg::LEN_CAP);
	assign received = {ck_hi_q, rx_byte};

	// Frame sequencer. Each byte moves the position on by one, except that the magic
	// word hunt can hold or restart and a refused length or the last checksum byte returns to
	// hunting. A disabled receiver drops the byte and leaves every piece of state alone.
	always_comb begin
		pos_next     = pos_q;
		len_next     = len_q;
		ck_hi_load   = 1'b0;
		res_valid    = 1'b0;
		res_kind     = mlfd_pkg::KIND_DATA;
		res_payload  = '0;
		res_length   = '0;
		res_checksum = '0;
		fl_ctl       = '0;
		if (enable_q) begin
			if (pos_q == mlfd_pkg::POS_HUNT) begin
				if (rx_byte == magic_q[15:8]) begin
					pos_next = mlfd_pkg::POS_MAGIC_LO;
				end
			end else if (pos_q == mlfd_pkg::POS_MAGIC_LO) begin
				// A failed second byte may itself start a new marker.
				if (rx_byte == magic_q[7:0]) begin
					pos_next = mlfd_pkg::POS_LEN_HI;
				end else if (rx_byte == magic_q[15:8]) begin
					pos_next = mlfd_pkg::POS_MAGIC_LO;
				end else begin
					pos_next = mlfd_pkg::POS_HUNT;
				end
			end else if (pos_q == mlfd_pkg::POS_LEN_HI) begin
				len_next = {rx_byte, 8'h00};
				pos_next = mlfd_pkg::POS_LEN_LO;
			end else if (pos_q == mlfd_pkg::POS_LEN_LO) begin
				len_next = len_full;
				if (len_bad) begin
					pos_next   = mlfd_pkg::POS_HUNT;
					res_valid  = 1'b1;
					res_kind   = mlfd_pkg::KIND_BAD_LEN;
					res_length = len_full;
				end else begin
					pos_next     = mlfd_pkg::POS_PAYLOAD;
					fl_ctl.clear = 1'b1;
				end
			end else if (idx < {1'b0, len_q}) begin
				// Payload byte: pass it on and fold it into the checksum.
				fl_ctl.update = 1'b1;
				pos_next      = pos_q + 17'd1;
				res_valid     = 1'b1;
				res_kind      = mlfd_pkg::KIND_DATA;
				res_payload   = rx_byte;
			end else if (idx == {1'b0, len_q}) begin
				ck_hi_load = 1'b1;
				pos_next   = pos_q + 17'd1;
			end else begin
				// Last checksum byte, also taken for any position past the checksum.
				pos_next     = mlfd_pkg::POS_HUNT;
				res_valid    = 1'b1;
				res_kind     = (received == computed) ? mlfd_pkg::KIND_GOOD
					: mlfd_pkg::KIND_BAD_SUM;
				res_length   = len_q;
				res_checksum = received;
			end
		end
	end

	mlfd_fletcher u_fletcher (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (in_fire ? fl_ctl : '0),
		.data       (rx_byte),
		.check_word (computed)
	);

	// Frame state advances on every accepted byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			len_q   <= '0;
			ck_hi_q <= '0;
		end else if (in_fire) begin
			pos_q <= pos_next;
			len_q <= len_next;
			if (ck_hi_load) begin
				ck_hi_q <= rx_byte;
			end
		end
	end

	// Output register: loaded when a byte yields a result, emptied by an output
	// transaction that is not replaced in the same cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_fire && res_valid) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && res_valid) begin
			kind_q     <= res_kind;
			payload_q  <= res_payload;
			length_q   <= res_length;
			checksum_q <= res_checksum;
		end
	end

	assign out_valid      = out_valid_q;
	assign kind           = kind_q;
	assign payload_byte   = payload_q;
	assign frame_length   = length_q;
	assign frame_checksum = checksum_q;

	// The position never runs past the last checksum byte.
	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(pos_q >= mlfd_pkg::POS_PAYLOAD) |->
		({1'b0, pos_q} <= 18'(mlfd_pkg::HEADER_BYTES) + {2'b00, len_q} + 18'd1))
		else $error("frame position beyond checksum");

	// A byte taken while disabled leaves the frame position untouched.
	a_disabled_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && !enable_q) |=> $stable(pos_q))
		else $error("frame state changed while receiver disabled");

	// A refused length always sends the receiver back to hunting.
	a_bad_len_hunt: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && res_valid && res_kind == mlfd_pkg::KIND_BAD_LEN) |=>
		(pos_q == mlfd_pkg::POS_HUNT))
		else $error("no return to hunting after invalid length");

	// Payload results carry no frame length or checksum.
	a_data_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && kind_q == mlfd_pkg::KIND_DATA) |->
		(length_q == 16'd0 && checksum_q == 16'd0))
		else $error("payload result with frame fields set");

endmodule

// ----- dv/magic_length_fletcher_deframer_tb.sv -----
`timescale 1ns / 1ps
// Testbench for the magic-word Fletcher-16 frame receiver: random framed traffic and a predictor.
module magic_length_fletcher_deframer_tb;

	localparam int HALF_PERIOD = 5;
	localparam int RESET_CYCLES = 8;
	// Enabled bytes to offer before the random part stops.
	localparam int ITEM_TARGET = 1750;
	// The longest legitimate quiet spell is the output hold-off below; this is ten times that.
	localparam int STALL_LIMIT = 3000;
	localparam int HOLD_CYCLES = 300;
	localparam int REPORT_LIMIT = 10;
	localparam int PRESSURE_PHASE = 4;
	localparam int STEADY_PHASE = 7;

	typedef struct packed {
		mlfd_pkg::kind_t kind;
		logic [7:0]      data;
		logic [15:0]     length;
		logic [15:0]     checksum;
	} frame_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  rx_byte = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  kind;
	logic [7:0]  payload_byte;
	logic [15:0] frame_length;
	logic [15:0] frame_checksum;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;

	// Bytes waiting to be offered, and the results that accepted bytes are owed.
	logic [7:0]    byte_queue[$];
	frame_result_t frame_results_due[$];

	// The predictor's own copy of the registers and of the frame state, at their reset values.
	logic        rx_enabled = 1'b0;
	logic [15:0] rx_marker = 16'h0000;
	logic [15:0] rx_len_limit = 16'd256;
	logic [16:0] frame_pos = '0;
	logic [15:0] frame_len = '0;
	logic [7:0]  fl_low = '0;
	logic [7:0]  fl_high = '0;
	logic [7:0]  chk_first = '0;

	// Flags set by the stimulus process: no random idling at all, and the output hold-off.
	logic steady = 1'b0;
	logic pressure = 1'b0;

	logic        in_fire = 1'b0;
	int          hold_left = 0;
	logic        hold_done = 1'b0;
	int          idle_cycles = 0;
	int unsigned mismatches = 0;
	int unsigned bytes_taken = 0;
	int unsigned pushed_total = 0;
	int unsigned queued_items = 0;
	int unsigned register_writes = 0;
	int unsigned phase = 0;
	int unsigned kind_counts[4] = '{default: 0};

	magic_length_fletcher_deframer i_dut (
		.clk,
		.arst_n,
		.in_valid,
		.in_ready,
		.rx_byte,
		.out_valid,
		.out_ready,
		.kind,
		.payload_byte,
		.frame_length,
		.frame_checksum,
		.cfg_valid,
		.cfg_ready,
		.cfg_index,
		.cfg_data
	);

	always #(HALF_PERIOD) clk = ~clk;

	// Works out what one accepted byte does to the frame state and queues any result it causes.
	function automatic void deframe_byte(input logic [7:0] b);
		frame_result_t res;
		logic [16:0]   offset;
		int unsigned   acc;
		bit            emit;
		res = '0;
		emit = 1'b0;
		if (!rx_enabled) begin
			// A disabled receiver drops the byte and keeps every bit of its state.
			return;
		end
		case (frame_pos)
			mlfd_pkg::POS_HUNT: begin
				if (b == rx_marker[15:8])
					frame_pos = mlfd_pkg::POS_MAGIC_LO;
			end
			mlfd_pkg::POS_MAGIC_LO: begin
				// A wrong second byte restarts the hunt, unless it could itself start a marker.
				if (b == rx_marker[7:0])
					frame_pos = mlfd_pkg::POS_LEN_HI;
				else if (b == rx_marker[15:8])
					frame_pos = mlfd_pkg::POS_MAGIC_LO;
				else
					frame_pos = mlfd_pkg::POS_HUNT;
			end
			mlfd_pkg::POS_LEN_HI: begin
				frame_len = {b, 8'h00};
				frame_pos = mlfd_pkg::POS_LEN_LO;
			end
			mlfd_pkg::POS_LEN_LO: begin
				frame_len = {frame_len[15:8], b};
				if (frame_len > rx_len_limit || {1'b0, frame_len} > mlfd_pkg::LEN_CAP) begin
					frame_pos = mlfd_pkg::POS_HUNT;
					res.kind = mlfd_pkg::KIND_BAD_LEN;
					res.length = frame_len;
					emit = 1'b1;
				end else begin
					frame_pos = mlfd_pkg::POS_PAYLOAD;
					fl_low = '0;
					fl_high = '0;
				end
			end
			default: begin
				offset = frame_pos - mlfd_pkg::POS_PAYLOAD;
				if (offset < {1'b0, frame_len}) begin
					acc = (int'(fl_low) + int'(b)) % 255;
					fl_low = acc[7:0];
					acc = (int'(fl_high) + int'(fl_low)) % 255;
					fl_high = acc[7:0];
					frame_pos = frame_pos + 17'd1;
					res.kind = mlfd_pkg::KIND_DATA;
					res.data = b;
					emit = 1'b1;
				end else if (offset == {1'b0, frame_len}) begin
					chk_first = b;
					frame_pos = frame_pos + 17'd1;
				end else begin
					// Last checksum byte; any position further on is treated the same way.
					res.checksum = {chk_first, b};
					res.length = frame_len;
					if (res.checksum == {fl_high, fl_low})
						res.kind = mlfd_pkg::KIND_GOOD;
					else
						res.kind = mlfd_pkg::KIND_BAD_SUM;
					frame_pos = mlfd_pkg::POS_HUNT;
					emit = 1'b1;
				end
			end
		endcase
		if (emit)
			frame_results_due.push_back(res);
	endfunction

	function automatic void report_mismatch(input string what, input frame_result_t want);
		mismatches++;
		if (mismatches <= REPORT_LIMIT) begin
			$write("%0t: %s: expected kind %0d byte %02h length %0d checksum %04h, ",
				$time, what, want.kind, want.data, want.length, want.checksum);
			$display("got kind %0d byte %02h length %0d checksum %04h",
				kind, payload_byte, frame_length, frame_checksum);
		end
	endfunction

	function automatic void offer_byte(input logic [7:0] b);
		byte_queue.push_back(b);
		pushed_total++;
	endfunction

	// Builds one frame with a random payload. A corrupt frame carries a wrong checksum; a non-zero
	// keep cuts the frame off after that many bytes.
	function automatic void queue_frame(input logic [15:0] marker, input logic [15:0] len,
			input bit corrupt, input int unsigned keep);
		logic [7:0]  frame[$];
		int unsigned lo_acc;
		int unsigned hi_acc;
		logic [15:0] chk;
		logic [7:0]  b;
		lo_acc = 0;
		hi_acc = 0;
		frame = {marker[15:8], marker[7:0], len[15:8], len[7:0]};
		for (int i = 0; i < len; i++) begin
			b = 8'($urandom);
			lo_acc = (lo_acc + b) % 255;
			hi_acc = (hi_acc + lo_acc) % 255;
			frame.push_back(b);
		end
		chk = {hi_acc[7:0], lo_acc[7:0]};
		if (corrupt)
			chk ^= 16'($urandom_range(65535, 1));
		frame.push_back(chk[15:8]);
		frame.push_back(chk[7:0]);
		if (keep == 0 || keep > frame.size())
			keep = frame.size();
		for (int i = 0; i < keep; i++)
			offer_byte(frame[i]);
	endfunction

	// Mostly short payloads, now and then the longest one the limit allows, capped at 300.
	function automatic logic [15:0] pick_length(input logic [15:0] limit);
		int unsigned cap;
		cap = (limit < 16'd24) ? limit : 24;
		if ($urandom_range(19) == 0)
			return (limit < 16'd300) ? limit : 16'd300;
		return 16'($urandom_range(cap));
	endfunction

	// One slice of traffic: mostly well-formed frames, the rest noise and broken sequences.
	function automatic void add_traffic(input logic [15:0] marker, input logic [15:0] limit);
		int unsigned choice;
		logic [7:0]  b;
		logic [15:0] len;
		choice = $urandom_range(99);
		len = pick_length(limit);
		if (choice < 10) begin
			// Line noise. It only carries the marker high byte where no huge length can follow.
			repeat ($urandom_range(1, 6)) begin
				b = 8'($urandom);
				if (b == marker[15:8] && limit > 16'd300)
					b = ~b;
				offer_byte(b);
			end
		end else if (choice < 60) begin
			queue_frame(marker, len, 1'b0, 0);
		end else if (choice < 75) begin
			queue_frame(marker, len, 1'b1, 0);
		end else if (choice < 85 && limit != 16'hFFFF) begin
			// A refused length: only the header and a few trailing bytes are sent, since the
			// receiver goes back to hunting straight after the length.
			case ($urandom_range(3))
				0: len = 16'hFFFF;
				1: len = limit + 16'd1;
				default: len = 16'($urandom_range(65535, limit + 1));
			endcase
			queue_frame(marker, len, 1'b0, $urandom_range(4, 12));
		end else if (choice < 92) begin
			queue_frame(marker, len, 1'b0, $urandom_range(1, len + 5));
		end else begin
			// A false start: the marker high byte followed by anything but the low byte.
			b = 8'($urandom);
			if (b == marker[7:0])
				b = (marker[15:8] == marker[7:0]) ? ~b : marker[15:8];
			offer_byte(marker[15:8]);
			offer_byte(b);
			queue_frame(marker, len, 1'b0, 0);
		end
	endfunction

	// A register write is one transaction on the configuration channel; the predictor takes the
	// new value at the edge that accepts it.
	task automatic write_register(input mlfd_pkg::cfg_idx_t idx, input logic [15:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do
			@(posedge clk);
		while (!(cfg_valid && cfg_ready));
		case (idx)
			mlfd_pkg::CFG_ENABLE: rx_enabled = value[0];
			mlfd_pkg::CFG_MAGIC: rx_marker = value;
			mlfd_pkg::CFG_MAX_LEN: rx_len_limit = value;
			default: ;
		endcase
		register_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Waits until every queued byte has been taken and every owed result has arrived, then lets
	// a byte that causes no result work its way through.
	task automatic settle();
		wait (byte_queue.size() == 0 && !in_valid);
		wait (frame_results_due.size() == 0);
		repeat (4) @(posedge clk);
	endtask

	// Byte sender. A transaction that has been offered stays on the port until it is taken; only
	// then may the sender idle or move on to the next byte.
	always @(negedge clk) begin
		if (in_valid && !in_fire) begin
			// Still waiting for the receiver to take the current byte.
		end else if (arst_n && byte_queue.size() != 0 &&
				(steady || $urandom_range(99) >= 20)) begin
			in_valid <= 1'b1;
			rx_byte <= byte_queue.pop_front();
		end else begin
			in_valid <= 1'b0;
		end
	end

	// Result receiver. Once in the run it holds off for a long spell so that the output register
	// fills and the block has to stall its input.
	always @(negedge clk) begin
		if (pressure && !hold_done) begin
			hold_left = HOLD_CYCLES;
			hold_done = 1'b1;
		end
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= steady || ($urandom_range(99) >= 20);
		end
	end

	// Monitor: takes accepted bytes into the predictor, checks each accepted result against the
	// oldest one owed, and watches for the run going quiet.
	always @(posedge clk) begin
		frame_result_t want;
		in_fire <= in_valid && in_ready;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (frame_results_due.size() == 0) begin
					report_mismatch("result with nothing owed", '0);
				end else begin
					want = frame_results_due.pop_front();
					kind_counts[want.kind]++;
					if (kind !== want.kind || payload_byte !== want.data ||
							frame_length !== want.length || frame_checksum !== want.checksum)
						report_mismatch("wrong result", want);
				end
			end
			if (in_valid && in_ready) begin
				bytes_taken++;
				deframe_byte(rx_byte);
			end
			if ((in_valid && in_ready) || (out_valid && out_ready) ||
					(cfg_valid && cfg_ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
				if (idle_cycles >= STALL_LIMIT) begin
					$display("Watchdog: no transaction for %0d cycles, %0d results still owed",
						STALL_LIMIT, frame_results_due.size());
					$display("[magic_length_fletcher_deframer] ERROR");
					$finish;
				end
			end
		end
	end

	initial begin
		logic [7:0]  seq[$];
		logic [15:0] marker;
		logic [15:0] limit;
		bit          on;
		int unsigned start_count;
		int unsigned frames;

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Straight out of reset the receiver is disabled, so these bytes must vanish.
		offer_byte(8'h00);
		offer_byte(8'hFF);
		settle();
		write_register(mlfd_pkg::CFG_MAGIC, 16'hA55A);
		write_register(mlfd_pkg::CFG_MAX_LEN, 16'd3);
		write_register(mlfd_pkg::CFG_ENABLE, 16'd1);

		// The marker high byte twice over, then a zero-length frame whose check word is zero. Next
		// a length above the limit whose low byte equals the marker high byte: it must not be taken
		// as the start of a new marker. Then a two-byte frame with a wrong checksum; last a header.
		seq = {8'hA5, 8'hA5, 8'h5A, 8'h00, 8'h00, 8'h00, 8'h00,
			8'hA5, 8'h5A, 8'h00, 8'hA5, 8'h5A,
			8'hA5, 8'h5A, 8'h00, 8'h02, 8'hFF, 8'h00, 8'h12, 8'h34,
			8'hA5, 8'h5A, 8'h00, 8'h01};
		foreach (seq[i])
			offer_byte(seq[i]);
		settle();

		// The frame above is cut off by a disable; it must resume where it stopped.
		write_register(mlfd_pkg::CFG_ENABLE, 16'd0);
		offer_byte(8'h77);
		settle();
		write_register(mlfd_pkg::CFG_ENABLE, 16'd1);
		seq = {8'h33, 8'h33, 8'h33};
		foreach (seq[i])
			offer_byte(seq[i]);
		settle();

		// Random phases, each with its own settings. The early ones pin the register extremes,
		// one applies back-pressure and one runs with no idling on either side.
		while (queued_items < ITEM_TARGET) begin
			phase++;
			marker = 16'($urandom);
			case ($urandom_range(5))
				0: marker = 16'h0000;
				1: marker = 16'hFFFF;
				2: marker = {marker[7:0], marker[7:0]};
				default: ;
			endcase
			limit = 16'($urandom_range(48));
			case ($urandom_range(7))
				0: limit = 16'h0000;
				1: limit = 16'hFFFF;
				2: limit = 16'd256;
				default: ;
			endcase
			on = ($urandom_range(7) != 0);
			if (phase == 1) begin
				marker = 16'hFFFF;
				limit = 16'h0000;
				on = 1'b1;
			end else if (phase == 2) begin
				marker = 16'h0000;
				limit = 16'hFFFF;
				on = 1'b1;
			end else if (phase == PRESSURE_PHASE) begin
				limit = 16'hFFFF;
				on = 1'b1;
			end
			write_register(mlfd_pkg::CFG_MAGIC, marker);
			write_register(mlfd_pkg::CFG_MAX_LEN, limit);
			write_register(mlfd_pkg::CFG_ENABLE, {15'd0, on});
			steady = (phase == STEADY_PHASE);
			start_count = pushed_total;
			if (phase == PRESSURE_PHASE) begin
				// A long frame keeps the sender busy while the receiver holds off.
				pressure = 1'b1;
				queue_frame(marker, 16'd400, 1'b0, 0);
			end else if (!on) begin
				repeat ($urandom_range(4, 24))
					offer_byte(8'($urandom));
			end else begin
				frames = steady ? 12 : $urandom_range(2, 6);
				repeat (frames)
					add_traffic(marker, limit);
			end
			settle();
			pressure = 1'b0;
			steady = 1'b0;
			if (on)
				queued_items += pushed_total - start_count;
		end

		repeat (8) @(posedge clk);
		$display("Covered %0d accepted bytes in %0d random phases, %0d register writes, %0d-cycle hold-off.",
			bytes_taken, phase, register_writes, HOLD_CYCLES);
		$display("Checked %0d payload bytes, %0d good, %0d bad sums, %0d bad lengths; %0d mismatches.",
			kind_counts[mlfd_pkg::KIND_DATA], kind_counts[mlfd_pkg::KIND_GOOD],
			kind_counts[mlfd_pkg::KIND_BAD_SUM], kind_counts[mlfd_pkg::KIND_BAD_LEN], mismatches);
		if (mismatches == 0 && frame_results_due.size() == 0)
			$display("[magic_length_fletcher_deframer] OK");
		else
			$display("[magic_length_fletcher_deframer] ERROR");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/mlfd_pkg.sv
rtl/mlfd_fletcher.sv
rtl/magic_length_fletcher_deframer.sv
dv/magic_length_fletcher_deframer_tb.sv
